@@ rtl/deds_pkg.sv @@
// Shared types and constants for the deadline-estimating disk scheduler.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
package deds_pkg;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  request_tag;
    logic [47:0] start_sector;
    logic [15:0] sector_count;
    logic [62:0] deadline_us;
    logic [62:0] now_us;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_tag;
    logic [47:0] out_start_sector;
    logic [15:0] out_sector_count;
    logic        queue_empty;
  } rsp_t;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [2:0] ST_NOTHING  = 3'd0;
  localparam logic [2:0] ST_EXPIRING = 3'd1;
  localparam logic [2:0] ST_ELEVATOR = 3'd2;
  localparam logic [2:0] ST_WRAP     = 3'd3;
  localparam logic [2:0] ST_ALIAS    = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_ADDED    = 3'd6;

  localparam logic [1:0] REG_SEEK     = 2'd0;
  localparam logic [1:0] REG_ROTATION = 2'd1;
  localparam logic [1:0] REG_TRANSFER = 2'd2;

  localparam logic [23:0] SEEK_RESET     = 24'd19000;
  localparam logic [23:0] ROTATION_RESET = 24'd11111;
  localparam logic [15:0] TRANSFER_RESET = 16'd78;

  localparam logic [62:0] NO_DEADLINE = {63{1'b1}};

  // One request as held in a cell of the deadline chain.
  typedef struct packed {
    logic        valid;
    logic [7:0]  tag;
    logic [47:0] start;
    logic [15:0] count;
    logic [62:0] deadline;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef struct packed {
    op_e         op;
    entry_t      ins;       // item to insert
    logic        ins_tail;  // insert with no deadline: goes to the tail
    logic [47:0] rm_start;  // remove the cell holding this start sector
  } chain_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_REMOVE,
    S_INSERT,
    S_REPORT
  } state_e;

endpackage

@@ rtl/deds_cell.sv @@
// One cell of the deadline-ordered chain: holds one request, shifts with neighbors.
// Depends on deds_pkg.
`timescale 1ns / 1ps
module deds_cell
  import deds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  input  entry_t     left,       // neighbor toward the head
  input  logic       left_ins,   // left neighbor's insert point is at or before it
  input  logic       left_gone,  // removal found at or before the left neighbor
  input  entry_t     right,      // neighbor toward the tail
  output entry_t     mine,
  output logic       ins_here,   // insert point at or before this cell
  output logic       gone_here   // removed entry at or before this cell
);

  logic   beats;
  logic   match;
  entry_t mine_next;

  // The new item goes before the first entry with a later deadline, or the first empty cell.
  assign beats = !mine.valid ||
                 (!ctl.ins_tail && mine.deadline == NO_DEADLINE) ||
                 (!ctl.ins_tail && ctl.ins.deadline < mine.deadline);
  assign ins_here  = left_ins || beats;
  assign match     = mine.valid && mine.start == ctl.rm_start;
  assign gone_here = left_gone || match;

  always_comb begin
    mine_next = mine;
    case (ctl.op)
      OP_INSERT: begin
        if (left_ins) mine_next = left;
        else if (beats) mine_next = ctl.ins;
      end
      OP_REMOVE: begin
        if (gone_here) mine_next = right;
      end
      default: mine_next = mine;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mine.valid <= 1'b0;
    end else begin
      mine.valid <= mine_next.valid;
    end
    mine.tag      <= mine_next.tag;
    mine.start    <= mine_next.start;
    mine.count    <= mine_next.count;
    mine.deadline <= mine_next.deadline;
  end

endmodule

@@ rtl/deds_chain.sv @@
// Row of cells kept in deadline order; cell 0 is the deadline head.
// Depends on deds_pkg and deds_cell.
`timescale 1ns / 1ps
module deds_chain
  import deds_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  output entry_t     cells [DEPTH]
);

  logic ins_at  [DEPTH];
  logic gone_at [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t l, r;
    logic   li, lg;
    if (i == 0) begin : g_head
      assign l  = '0;
      assign li = 1'b0;
      assign lg = 1'b0;
    end else begin : g_body
      assign l  = cells[i-1];
      assign li = ins_at[i-1];
      assign lg = gone_at[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r = '0;
    end else begin : g_mid
      assign r = cells[i+1];
    end
    deds_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .left     (l),
      .left_ins (li),
      .left_gone(lg),
      .right    (r),
      .mine     (cells[i]),
      .ins_here (ins_at[i]),
      .gone_here(gone_at[i])
    );
  end

endmodule

@@ rtl/deadline_estimating_disk_scheduler.sv @@
// Top level of the deadline-estimating disk scheduler: control sequencer,
// cost estimate and sector scan over a chain of cells. Depends on deds_pkg, deds_chain.
`timescale 1ns / 1ps
//
// channel   direction  handshake              payload
// command   in         start & !busy          req (req_t)
// result    out        done, one cycle        rsp (rsp_t)
// config    in         cfg_we                 cfg_index, cfg_data
//
// Every item, an empty dispatch included, yields its result in the report
// state: one scan pass walks the cell chain one cell per cycle to find the
// alias, the elevator successor and the lowest sector; then come the decide,
// remove, insert and report states, in that order.
// busy stays high through the report cycle and drops the cycle after done,
// so a new item is taken only once the previous one has been reported.
// Reset is synchronous: the chain empties, the elevator clears and the
// timing registers return to their defaults. The receiver cannot stall.
//
// Requests live in the chain in deadline order. A served request is found
// by its start sector, which is unique among held requests.
module deadline_estimating_disk_scheduler
  import deds_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [23:0] seek_time_us, rotation_time_us;
  logic [15:0] transfer_time_us;

  state_e state, state_next;
  req_t   cur;
  logic [IW-1:0] scan_idx;

  entry_t     cells [DEPTH];
  chain_ctl_t ctl;

  // Elevator: tracked by start sector, since cells move.
  logic        elev_valid;
  logic [47:0] elev_start;

  // Scan results.
  logic        alias_hit, succ_hit, low_hit, elev_found;
  logic [47:0] succ_start, low_start;
  logic [CW-1:0] fill;

  // Served request and its outcome.
  logic [2:0]  status;
  logic        serve_any;
  logic [47:0] key;       // sector the successor scan runs from
  logic [47:0] key_reg;

  // Estimate pipeline.
  logic [39:0] prod_xfer;
  logic [31:0] prod_rot;
  logic [63:0] limit;
  logic        expire;

  entry_t sc;
  assign sc = cells[scan_idx];

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seek_time_us     <= SEEK_RESET;
      rotation_time_us <= ROTATION_RESET;
      transfer_time_us <= TRANSFER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEEK:     seek_time_us     <= cfg_data;
        REG_ROTATION: rotation_time_us <= cfg_data;
        REG_TRANSFER: transfer_time_us <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (scan_idx == IW'(DEPTH - 1)) state_next = S_DECIDE;
      S_DECIDE: state_next = S_REMOVE;
      S_REMOVE: state_next = S_INSERT;
      S_INSERT: state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) cur <= req;
    if (state == S_IDLE) scan_idx <= '0;
    else if (state == S_SCAN) scan_idx <= scan_idx + 1'b1;
  end

  // ---------------- estimate: products, then sum ----------------
  // Products in the scan cycles, sum in decide; head count is stable during the scan.
  always_ff @(posedge clk) begin
    prod_xfer <= 40'(transfer_time_us) * 40'(cells[0].count);
    prod_rot  <= 32'(cells[0].count[15:8]) * 32'(rotation_time_us);
  end

  always_comb begin
    limit = 64'(cur.now_us) + 64'(seek_time_us) + 64'(rotation_time_us)
          + 64'(prod_xfer) + 64'(prod_rot);
    if (limit[63]) limit = {1'b0, NO_DEADLINE};
    expire = cells[0].valid && cells[0].deadline != NO_DEADLINE &&
             cells[0].deadline < limit[62:0];
  end

  // ---------------- decide (key of the successor scan) ----------------
  always_comb begin
    key = cur.start_sector;
    if (cur.cmd == CMD_DISPATCH) begin
      if (expire)          key = cells[0].start;
      else if (elev_valid) key = elev_start;
      else                 key = low_start;
    end
  end

  // ---------------- scan over the chain, one cell a cycle ----------------
  // First pass: alias, lowest sector, fill. Successor of the served sector
  // needs the served sector first, so a second value runs over the same
  // cells through `elev_found`/succ: the scan key is taken as the alias sector
  // for adds or is refined after decide. To keep one pass, track successors
  // of three candidates is costly; instead track successor of the add sector
  // and of the elevator, head and lowest sectors, in parallel below.
  logic        s_add_hit, s_elv_hit, s_hd_hit, s_low_hit;
  logic [47:0] s_add, s_elv, s_hd, s_low2;

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      alias_hit <= 1'b0; low_hit <= 1'b0; fill <= '0; elev_found <= 1'b0;
      s_add_hit <= 1'b0; s_elv_hit <= 1'b0; s_hd_hit <= 1'b0; s_low_hit <= 1'b0;
    end else if (state == S_SCAN && sc.valid) begin
      fill <= fill + 1'b1;
      if (sc.start == cur.start_sector) alias_hit <= 1'b1;
      if (elev_valid && sc.start == elev_start) elev_found <= 1'b1;
      if (!low_hit || sc.start < low_start) begin
        low_hit <= 1'b1; low_start <= sc.start;
      end
      if (sc.start > cur.start_sector && (!s_add_hit || sc.start < s_add)) begin
        s_add_hit <= 1'b1; s_add <= sc.start;
      end
      if (sc.start > elev_start && (!s_elv_hit || sc.start < s_elv)) begin
        s_elv_hit <= 1'b1; s_elv <= sc.start;
      end
      if (sc.start > cells[0].start && (!s_hd_hit || sc.start < s_hd)) begin
        s_hd_hit <= 1'b1; s_hd <= sc.start;
      end
      // Successor of the lowest sector is the second lowest.
      if (!low_hit || sc.start < low_start) begin
        s_low_hit <= low_hit; s_low2 <= low_start;
      end else if (!s_low_hit || sc.start < s_low2) begin
        s_low_hit <= 1'b1; s_low2 <= sc.start;
      end
    end
  end

  always_comb begin
    succ_hit = s_add_hit; succ_start = s_add;
    if (cur.cmd == CMD_DISPATCH) begin
      if (expire) begin
        succ_hit = s_hd_hit; succ_start = s_hd;
      end else if (elev_valid) begin
        succ_hit = s_elv_hit; succ_start = s_elv;
      end else begin
        succ_hit = s_low_hit; succ_start = s_low2;
      end
    end
  end

  // ---------------- decide: latch outcome ----------------
  logic do_insert;
  always_ff @(posedge clk) begin
    if (rst) begin
      elev_valid <= 1'b0;
      elev_start <= '0;
    end else if (state == S_DECIDE) begin
      serve_any <= 1'b0;
      do_insert <= 1'b0;
      status    <= ST_NOTHING;
      if (cur.cmd == CMD_DISPATCH) begin
        if (fill != '0) begin
          serve_any <= 1'b1;
          status <= expire ? ST_EXPIRING : (elev_valid ? ST_ELEVATOR : ST_WRAP);
        end
      end else begin
        if (alias_hit) begin
          serve_any <= 1'b1; do_insert <= 1'b1; status <= ST_ALIAS;
        end else if (fill == CW'(DEPTH)) begin
          status <= ST_FULL;
        end else begin
          do_insert <= 1'b1; status <= ST_ADDED;
        end
      end
      // Elevator update on a serve, unless a nonzero elevator sector is still held and was not the one served.
      if ((cur.cmd == CMD_DISPATCH && fill != '0) ||
          (cur.cmd == CMD_ADD && alias_hit)) begin
        if (!(elev_valid && elev_found && elev_start != key && elev_start != '0)) begin
          elev_valid <= succ_hit;
          elev_start <= succ_start;
        end
      end
    end
  end

  // Capture the served entry just before it leaves the chain.
  always_ff @(posedge clk) if (state == S_DECIDE) key_reg <= key;

  entry_t served_rm;
  always_comb begin
    served_rm = '0;
    for (int i = 0; i < DEPTH; i++)
      if (cells[i].valid && cells[i].start == key_reg) served_rm = cells[i];
  end

  entry_t served_out;
  always_ff @(posedge clk) if (state == S_REMOVE) served_out <= served_rm;

  // ---------------- chain control ----------------
  always_comb begin
    ctl = '0;
    ctl.op = OP_HOLD;
    ctl.rm_start = key_reg;
    ctl.ins.valid    = 1'b1;
    ctl.ins.tag      = cur.request_tag;
    ctl.ins.start    = cur.start_sector;
    ctl.ins.count    = cur.sector_count;
    ctl.ins.deadline = (cur.deadline_us == '0) ? NO_DEADLINE : cur.deadline_us;
    ctl.ins_tail     = (ctl.ins.deadline == NO_DEADLINE);
    if (state == S_REMOVE && serve_any) ctl.op = OP_REMOVE;
    if (state == S_INSERT && do_insert) ctl.op = OP_INSERT;
  end

  deds_chain #(.DEPTH(DEPTH)) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cells(cells)
  );

  // ---------------- outputs ----------------
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_REPORT);
    rsp  = '0;
    rsp.status = status;
    if (serve_any) begin
      rsp.out_tag          = served_out.tag;
      rsp.out_start_sector = served_out.start;
      rsp.out_sector_count = served_out.count;
    end
    rsp.queue_empty = !cells[0].valid;
  end

`ifndef NO_ASSERTIONS
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT) |=> (state == S_IDLE))
    else $error("report not followed by idle");
  a_empty_served: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_NOTHING) |-> rsp.queue_empty)
    else $error("nothing served on a non-empty queue");
`endif

endmodule
